### rtl/sector_free_list_stack_top_macros.svh
// Assertion macros for the sector free list stack.
// Used by the top level; depends on nothing else.
`ifndef SECTOR_FREE_LIST_STACK_TOP_MACROS_SVH
`define SECTOR_FREE_LIST_STACK_TOP_MACROS_SVH

// check a condition on every clock edge outside reset
`define SFLS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check that a trigger is followed by a condition in the next cycle
`define SFLS_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### rtl/sfls_pkg.sv
// Shared types and constants for the sector free list stack.
// Used by the top level; depends on nothing else.
package sfls_pkg;

	localparam int SECTOR_W = 12;
	localparam int COUNT_W  = 13;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_RANGE = 3'd2;
	localparam logic [2:0] OP_FILL  = 3'd3;
	localparam logic [2:0] OP_EMPTY = 3'd4;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [SECTOR_W-1:0] sector;
		logic [COUNT_W-1:0]  end_sector;
	} req_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] alloc_sector;
		logic                ok;
		logic [COUNT_W-1:0]  available;
		logic [COUNT_W-1:0]  used;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RANGE,
		ST_FILL
	} state_t;

endpackage

### rtl/sfls_ram.sv
// Single write port, single read port RAM with registered read data.
// Holds the free sector numbers; depends on nothing else.
module sfls_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/sector_free_list_stack_top.sv
// Sector free list stack allocator: sequencer, counters and result register.
// Depends on sfls_pkg, sfls_ram and sector_free_list_stack_top_macros.svh.
//
// A request is taken when start is high and busy is low. Allocate, free,
// make empty and unknown opcodes leave busy low: a new request may
// follow in the next cycle, and the result shows on rsp with done high in
// the cycle after the request. Free range pushes sectors from sector up to
// min(end_sector, capacity) - 1 and fill reloads 0 to capacity - 1, one
// entry per cycle through the single write port; busy stays high meanwhile.
// After reset the block stays busy while the store is loaded in identity
// order; capacity writes are taken meanwhile.
// The receiver cannot stall: each result is on rsp for exactly one cycle.
`include "sector_free_list_stack_top_macros.svh"

module sector_free_list_stack_top #(
	parameter int MAX_SECTORS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  sfls_pkg::req_t                req,
	output logic                          done,
	output sfls_pkg::rsp_t                rsp,
	input  logic                          capacity_we,
	input  logic [sfls_pkg::COUNT_W-1:0]  capacity_wdata
);

	import sfls_pkg::*;

	localparam int AW = $clog2(MAX_SECTORS);
	localparam int CW = $clog2(MAX_SECTORS + 1);
	localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

	state_t              state_q, state_d;
	logic [WW-1:0]       idx_q, idx_d;
	logic [WW-1:0]       limit_q, limit_d;
	logic [WW-1:0]       cap_q;
	logic [CW-1:0]       top_q, top_d;
	logic [CW-1:0]       used_q, used_d;
	logic                done_q, done_d;
	logic                ok_q, ok_d;
	logic                sel_q, sel_d;

	logic [CW-1:0]       effcap;
	logic                accept;
	logic                in_run;
	logic                can_push;
	logic [CW-1:0]       top_inc, top_dec, used_inc, used_dec;
	logic [WW-1:0]       end_w, ecap_w, top_w, used_w;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [SECTOR_W-1:0] ram_wdata, ram_rdata;

	sfls_ram #(
		.DEPTH(MAX_SECTORS),
		.WIDTH(SECTOR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (cap_q == '0) begin
			effcap = CW'(1);
		end else if (cap_q > WW'(MAX_SECTORS)) begin
			effcap = CW'(MAX_SECTORS);
		end else begin
			effcap = cap_q[CW-1:0];
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && (state_q == ST_IDLE);
	assign in_run   = (idx_q < limit_q);
	assign can_push = (top_q < effcap);
	assign top_inc  = top_q + CW'(1);
	assign top_dec  = top_q - CW'(1);
	assign used_inc = (used_q < CW'(MAX_SECTORS)) ? used_q + CW'(1) : used_q;
	assign used_dec = (used_q != '0) ? used_q - CW'(1) : used_q;
	assign end_w    = WW'(req.end_sector);
	assign ecap_w   = WW'(effcap);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (!in_run) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && req.opcode == OP_RANGE) state_d = ST_RANGE;
				if (accept && req.opcode == OP_FILL) state_d = ST_FILL;
			end
			ST_RANGE, ST_FILL: begin
				if (!in_run) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		top_d     = top_q;
		used_d    = used_q;
		idx_d     = idx_q;
		limit_d   = limit_q;
		done_d    = 1'b0;
		ok_d      = 1'b0;
		sel_d     = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = top_q[AW-1:0];
		ram_wdata = idx_q[SECTOR_W-1:0];
		ram_raddr = top_dec[AW-1:0];
		case (state_q)
			ST_INIT: begin
				if (in_run) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[AW-1:0];
					idx_d     = idx_q + WW'(1);
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.opcode)
						OP_ALLOC: begin
							done_d = 1'b1;
							if (top_q != '0) begin
								ram_re = 1'b1;
								top_d  = top_dec;
								used_d = used_inc;
								ok_d   = 1'b1;
								sel_d  = 1'b1;
							end
						end
						OP_FREE: begin
							done_d = 1'b1;
							if (can_push) begin
								ram_we    = 1'b1;
								ram_wdata = req.sector;
								top_d     = top_inc;
								used_d    = used_dec;
								ok_d      = 1'b1;
							end
						end
						OP_RANGE: begin
							idx_d   = WW'(req.sector);
							limit_d = (end_w < ecap_w) ? end_w : ecap_w;
						end
						OP_FILL: begin
							idx_d   = '0;
							limit_d = ecap_w;
						end
						OP_EMPTY: begin
							done_d = 1'b1;
							ok_d   = 1'b1;
							top_d  = '0;
							used_d = effcap;
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			ST_RANGE: begin
				if (in_run) begin
					idx_d = idx_q + WW'(1);
					if (can_push) begin
						ram_we = 1'b1;
						top_d  = top_inc;
						used_d = used_dec;
					end
				end else begin
					done_d = 1'b1;
					ok_d   = 1'b1;
				end
			end
			ST_FILL: begin
				if (in_run) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[AW-1:0];
					idx_d     = idx_q + WW'(1);
				end else begin
					top_d  = effcap;
					used_d = '0;
					done_d = 1'b1;
					ok_d   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			idx_q   <= '0;
			limit_q <= WW'(MAX_SECTORS);
			cap_q   <= WW'(MAX_SECTORS);
			top_q   <= CW'(MAX_SECTORS);
			used_q  <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			limit_q <= limit_d;
			top_q   <= top_d;
			used_q  <= used_d;
			done_q  <= done_d;
			ok_q    <= ok_d;
			sel_q   <= sel_d;
			if (capacity_we) begin
				cap_q <= WW'(capacity_wdata);
			end
		end
	end

	assign top_w  = WW'(top_q);
	assign used_w = WW'(used_q);

	assign done             = done_q;
	assign rsp.alloc_sector = sel_q ? ram_rdata : '0;
	assign rsp.ok           = ok_q;
	assign rsp.available    = top_w[COUNT_W-1:0];
	assign rsp.used         = used_w[COUNT_W-1:0];

	`SFLS_ASSERT_ALWAYS(a_top_bound, clk, arst_n, top_q <= CW'(MAX_SECTORS), "stack top overflow")
	`SFLS_ASSERT_ALWAYS(a_used_bound, clk, arst_n, used_q <= CW'(MAX_SECTORS), "used overflow")
	`SFLS_ASSERT_ALWAYS(a_port_excl, clk, arst_n, !(ram_we && ram_re), "store read and write")
	`SFLS_ASSERT_ALWAYS(a_done_idle, clk, arst_n, !done_q || state_q == ST_IDLE, "done while busy")
	`SFLS_ASSERT_NEXT(a_alloc_pop, clk, arst_n, accept && req.opcode == OP_ALLOC && top_q != '0, done_q && ok_q && top_q == $past(top_q) - CW'(1), "allocate did not pop")

endmodule

### sim/sector_free_list_stack_checker.sv
// Response checker for the sector free list stack: tracks the free store, stack top,
// used count and capacity, predicts each response and compares it field by field.
// Depends on sfls_pkg; instantiated beside the block by sector_free_list_stack_top_tb.
`timescale 1ns / 1ps

module sector_free_list_stack_checker #(
	parameter int MAX_SECTORS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  sfls_pkg::req_t               req,
	input  logic                         done,
	input  sfls_pkg::rsp_t               rsp,
	input  logic                         capacity_we,
	input  logic [sfls_pkg::COUNT_W-1:0] capacity_wdata,
	output int                           errors,
	output int                           outstanding
);

	import sfls_pkg::*;

	logic [SECTOR_W-1:0] free_store [MAX_SECTORS];
	int unsigned         free_top;
	int unsigned         used_total;
	logic [COUNT_W-1:0]  capacity;
	rsp_t                rsp_pending [$];
	rsp_t                want;

	function automatic int unsigned eff_capacity();
		if (capacity == '0)
			return 1;
		if (capacity > MAX_SECTORS)
			return MAX_SECTORS;
		return 32'(capacity);
	endfunction

	function automatic void load_identity();
		int unsigned i;
		for (i = 0; i < eff_capacity(); i++)
			free_store[i] = i[SECTOR_W-1:0];
		free_top   = eff_capacity();
		used_total = 0;
	endfunction

	function automatic bit push_sector(int unsigned s);
		if (free_top >= eff_capacity() || free_top >= MAX_SECTORS)
			return 1'b0;
		free_store[free_top] = s[SECTOR_W-1:0];
		free_top++;
		if (used_total > 0)
			used_total--;
		return 1'b1;
	endfunction

	function automatic rsp_t alloc_response(req_t r);
		rsp_t        o;
		int unsigned i;
		o = '0;
		case (r.opcode)
			OP_ALLOC: begin
				if (free_top > 0) begin
					free_top--;
					if (free_top >= MAX_SECTORS)
						free_top = MAX_SECTORS - 1;
					o.alloc_sector = free_store[free_top];
					if (used_total < MAX_SECTORS)
						used_total++;
					o.ok = 1'b1;
				end
			end
			OP_FREE: begin
				o.ok = push_sector(32'(r.sector));
			end
			OP_RANGE: begin
				for (i = 32'(r.sector); i < 32'(r.end_sector); i++) begin
					if (i >= eff_capacity())
						break;
					void'(push_sector(i));
				end
				o.ok = 1'b1;
			end
			OP_FILL: begin
				load_identity();
				o.ok = 1'b1;
			end
			OP_EMPTY: begin
				free_top   = 0;
				used_total = eff_capacity();
				o.ok       = 1'b1;
			end
			default: begin
			end
		endcase
		o.available = free_top[COUNT_W-1:0];
		o.used      = used_total[COUNT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned k = 0; k < MAX_SECTORS; k++)
				free_store[k] = k[SECTOR_W-1:0];
			capacity = COUNT_W'(MAX_SECTORS);
			load_identity();
			rsp_pending.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (rsp_pending.size() == 0) begin
					$error("response with no request waiting");
					errors++;
				end else begin
					want = rsp_pending.pop_front();
					if (rsp.alloc_sector !== want.alloc_sector) begin
						$error("alloc_sector: expected %0d, got %0d",
							want.alloc_sector, rsp.alloc_sector);
						errors++;
					end
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
						errors++;
					end
					if (rsp.available !== want.available) begin
						$error("available: expected %0d, got %0d",
							want.available, rsp.available);
						errors++;
					end
					if (rsp.used !== want.used) begin
						$error("used: expected %0d, got %0d", want.used, rsp.used);
						errors++;
					end
				end
			end
			if (start && !busy)
				rsp_pending.push_back(alloc_response(req));
			if (capacity_we)
				capacity = capacity_wdata;
			outstanding <= rsp_pending.size();
		end
	end

endmodule

### sim/sector_free_list_stack_top_tb.sv
// Top of the sector free list stack testbench: clock, reset, capacity writes and requests.
// Depends on sfls_pkg, the block and sector_free_list_stack_checker.
`timescale 1ns / 1ps

module sector_free_list_stack_top_tb;
	import sfls_pkg::*;

	localparam int MAX_SECTORS = 4096;
	localparam int STALL_LIMIT = 20000;
	localparam int GAP_PCT     = 11;
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic               busy;
	req_t               req            = '0;
	logic               done;
	rsp_t               rsp;
	logic               capacity_we    = 1'b0;
	logic [COUNT_W-1:0] capacity_wdata = '0;
	int                 errors;
	int                 outstanding;
	int                 gap_pct        = GAP_PCT;
	int                 quiet          = 0;

	sector_free_list_stack_top #(.MAX_SECTORS(MAX_SECTORS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata)
	);

	sector_free_list_stack_checker #(.MAX_SECTORS(MAX_SECTORS)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic req_t make_req(logic [2:0] op, int unsigned s, int unsigned e);
		req_t r;
		r.opcode     = op;
		r.sector     = s[SECTOR_W-1:0];
		r.end_sector = e[COUNT_W-1:0];
		return r;
	endfunction

	task automatic issue(input req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic set_capacity(input int unsigned v);
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		capacity_we    <= 1'b1;
		capacity_wdata <= v[COUNT_W-1:0];
		@(posedge clk);
		capacity_we    <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned n, input int unsigned cap);
		int unsigned alloc_w;
		int unsigned pick;
		int unsigned s;
		int unsigned k;
		req_t        r;
		alloc_w = $urandom_range(25, 55);
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			s    = $urandom_range(cap - 1, 0);
			if (pick < 10) begin
				r = make_req(3'($urandom), $urandom, $urandom);
			end else begin
				pick = $urandom_range(99);
				if (pick < alloc_w)
					r = make_req(OP_ALLOC, $urandom, $urandom);
				else if (pick < alloc_w + 30)
					r = make_req(OP_FREE, s, $urandom);
				else if (pick < 90)
					r = make_req(OP_RANGE, s,
						s + $urandom_range(cap > 64 ? 12 : cap + 2, 0));
				else if (pick < 95)
					r = make_req(OP_FILL, $urandom, $urandom);
				else
					r = make_req(OP_EMPTY, $urandom, $urandom);
			end
			issue(r);
		end
	endtask

	initial begin
		int unsigned caps [12];
		int unsigned w;
		int unsigned eff;
		caps = '{1, 0, 16, 8191, 3, 4097, 64, 4096, 200, 7, 0, 2};
		wait (arst_n);
		@(posedge clk);

		issue(make_req(OP_ALLOC, 0, 0));
		issue(make_req(OP_FREE, 4095, 0));
		issue(make_req(OP_FREE, 123, 0));
		issue(make_req(OP_RANGE, 0, 0));
		issue(make_req(OP_UNUSED_FIRST, 4095, 8191));
		issue(make_req(OP_UNUSED_FIRST + 3'd1, 0, 4096));
		issue(make_req(OP_UNUSED_LAST, 2730, 5461));
		issue(make_req(OP_EMPTY, 0, 0));
		issue(make_req(OP_ALLOC, 0, 0));
		issue(make_req(OP_FREE, 4095, 0));
		issue(make_req(OP_RANGE, 4090, 4096));
		issue(make_req(OP_RANGE, 4095, 8191));
		issue(make_req(OP_RANGE, 100, 50));
		issue(make_req(OP_ALLOC, 0, 0));
		issue(make_req(OP_ALLOC, 0, 0));
		issue(make_req(OP_FILL, 0, 0));
		issue(make_req(OP_FREE, 0, 0));
		issue(make_req(OP_RANGE, 0, 4096));

		// leave the stack short of capacity with nothing used
		set_capacity(1);
		issue(make_req(OP_EMPTY, 0, 0));
		set_capacity(16);
		issue(make_req(OP_FREE, 3, 0));
		issue(make_req(OP_FREE, 4, 0));
		issue(make_req(OP_ALLOC, 0, 0));

		for (int p = 0; p < 12; p++) begin
			w = (p == 10) ? $urandom_range(300, 1) : caps[p];
			eff = (w == 0) ? 1 : ((w > MAX_SECTORS) ? MAX_SECTORS : w);
			set_capacity(w);
			gap_pct = (p == 5) ? 0 : GAP_PCT;
			if ($urandom_range(1) == 1)
				issue(make_req(OP_FILL, $urandom, $urandom));
			run_phase(eff > 300 ? 40 : 75, eff);
		end

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
